>>> sv/ansi_halfblock_encoder_unit_defines.svh
// Assertion macros for the ANSI half-block encoder.
`ifndef ANSI_HALFBLOCK_ENCODER_UNIT_DEFINES_SVH
`define ANSI_HALFBLOCK_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AHBE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define AHBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/ahbe_pkg.sv
// Shared types and constants of the ANSI half-block encoder.
package ahbe_pkg;

    localparam int SLOT_COUNT = 51;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int COLOUR_SLOTS = 19;
    localparam int BG_BASE    = 19;
    localparam int GLYPH_BASE = 38;
    localparam int NL_BASE    = 41;
    localparam int NUL_BASE   = 46;

    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_LBR  = 8'h5B;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_2    = 8'h32;
    localparam logic [7:0] CH_3    = 8'h33;
    localparam logic [7:0] CH_4    = 8'h34;
    localparam logic [7:0] CH_8    = 8'h38;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] GLYPH_0 = 8'hE2;
    localparam logic [7:0] GLYPH_1 = 8'h96;
    localparam logic [7:0] GLYPH_2 = 8'h80;

    typedef logic [5:0][2:0][3:0] digits_t;

    typedef struct packed {
        logic [SLOT_COUNT-1:0] mask;
        digits_t               digits;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic busy;
    } back_status_t;

endpackage

>>> sv/ahbe_front.sv
// Front end: colour packing, change detection, decimal split, slot mask build.
module ahbe_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          grayscale_mode,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    top_red,
    input  logic [7:0]    top_green,
    input  logic [7:0]    top_blue,
    input  logic [7:0]    bottom_red,
    input  logic [7:0]    bottom_green,
    input  logic [7:0]    bottom_blue,
    input  logic          row_first,
    input  logic          row_last,
    input  logic          image_last,
    input  ahbe_pkg::q_status_t q_status,
    output logic          q_push,
    output ahbe_pkg::job_t q_push_job
);
    import ahbe_pkg::*;

    logic [23:0] prev_top_reg, prev_top_next;
    logic [23:0] prev_bot_reg, prev_bot_next;
    logic        known_reg, known_next;
    logic [23:0] top_rgb, bot_rgb;
    logic        known_eff, fg_en, bg_en, accept;
    logic [5:0][7:0] chan;
    logic [5:0][11:0] dig;

    function automatic logic [11:0] to_digits(input logic [7:0] v);
        logic [1:0]  h;
        logic [6:0]  r;
        logic [14:0] p;
        logic [3:0]  t;
        logic [6:0]  o;
        if (v >= 8'd200)
        begin
            h = 2'd2;
            r = 7'(v - 8'd200);
        end
        else if (v >= 8'd100)
        begin
            h = 2'd1;
            r = 7'(v - 8'd100);
        end
        else
        begin
            h = 2'd0;
            r = v[6:0];
        end
        p = 15'(r) * 15'd205;
        t = p[14:11];
        o = r - ((7'(t) << 3) + (7'(t) << 1));
        return {2'b00, h, t, o[3:0]};
    endfunction

    function automatic logic [COLOUR_SLOTS-1:0] colour_mask(input logic en,
                                                           input logic [2:0][7:0] v);
        logic [COLOUR_SLOTS-1:0] m;
        m = '0;
        if (en)
        begin
            m[6:0] = 7'h7F;
            for (int c = 0; c < 3; c++)
            begin
                m[7 + 4*c]     = (v[c] >= 8'd100);
                m[7 + 4*c + 1] = (v[c] >= 8'd10);
                m[7 + 4*c + 2] = 1'b1;
                m[7 + 4*c + 3] = 1'b1;
            end
        end
        return m;
    endfunction

    assign top_rgb = grayscale_mode ? {top_red, top_red, top_red}
                                    : {top_red, top_green, top_blue};
    assign bot_rgb = grayscale_mode ? {bottom_red, bottom_red, bottom_red}
                                    : {bottom_red, bottom_green, bottom_blue};

    assign known_eff = known_reg && !row_first;
    assign fg_en     = !known_eff || (top_rgb != prev_top_reg);
    assign bg_en     = !known_eff || (bot_rgb != prev_bot_reg);

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = accept;

    assign chan[0] = top_rgb[23:16];
    assign chan[1] = top_rgb[15:8];
    assign chan[2] = top_rgb[7:0];
    assign chan[3] = bot_rgb[23:16];
    assign chan[4] = bot_rgb[15:8];
    assign chan[5] = bot_rgb[7:0];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            dig[i] = to_digits(chan[i]);
            q_push_job.digits[i][0] = dig[i][11:8];
            q_push_job.digits[i][1] = dig[i][7:4];
            q_push_job.digits[i][2] = dig[i][3:0];
        end
        q_push_job.mask = {image_last, image_last, image_last, image_last, image_last,
                           row_last, row_last, row_last, row_last, row_last,
                           3'b111,
                           colour_mask(bg_en, {chan[5], chan[4], chan[3]}),
                           colour_mask(fg_en, {chan[2], chan[1], chan[0]})};
    end

    always_comb
    begin
        prev_top_next = prev_top_reg;
        prev_bot_next = prev_bot_reg;
        known_next    = known_reg;
        if (accept)
        begin
            prev_top_next = top_rgb;
            prev_bot_next = bot_rgb;
            known_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_top_reg <= '0;
            prev_bot_reg <= '0;
            known_reg    <= 1'b0;
        end
        else
        begin
            prev_top_reg <= prev_top_next;
            prev_bot_reg <= prev_bot_next;
            known_reg    <= known_next;
        end
    end

endmodule

>>> sv/ahbe_queue.sv
// Short job queue between the front end and the byte sequencer.
module ahbe_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ahbe_pkg::job_t      push_job,
    input  logic                pop,
    output ahbe_pkg::job_t      head_job,
    output ahbe_pkg::q_status_t status
);
    import ahbe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign head_job = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/ahbe_back.sv
// Back end: walks the slot mask of one job and sends one byte per beat.
module ahbe_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ahbe_pkg::q_status_t    q_status,
    input  ahbe_pkg::job_t         head_job,
    output logic                   q_pop,
    output ahbe_pkg::back_status_t status,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             out_byte,
    output logic                   last_byte
);
    import ahbe_pkg::*;

    logic [SLOT_COUNT-1:0] mask_reg, mask_next;
    digits_t               digits_reg, digits_next;
    logic                  busy_reg, busy_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_byte_reg, out_byte_next;
    logic                  last_reg, last_next;

    logic [SLOT_COUNT-1:0] low, rest;
    logic [SLOT_W-1:0]     idx;
    logic [4:0]            loc;
    logic [3:0]            off;
    logic [2:0]            ch;
    logic [2:0]            tail;
    logic                  bg_sel, nul_sel, adv;
    logic [7:0]            col_byte, slot_byte;

    assign low  = mask_reg & (~mask_reg + 1'b1);
    assign rest = mask_reg & ~low;
    assign adv  = busy_reg && (!out_valid_reg || !out_stall);
    assign q_pop = (!busy_reg || (adv && (rest == '0))) && !q_status.empty;
    assign status.busy = busy_reg;

    always_comb
    begin
        idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (low[i])
            begin
                idx = idx | SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        bg_sel = (idx >= SLOT_W'(BG_BASE));
        loc    = bg_sel ? 5'(idx - SLOT_W'(BG_BASE)) : 5'(idx);
        off    = 4'(loc - 5'd7);
        ch     = (bg_sel ? 3'd3 : 3'd0) + {1'b0, off[3:2]};
        case (loc)
            5'd0:    col_byte = CH_ESC;
            5'd1:    col_byte = CH_LBR;
            5'd2:    col_byte = bg_sel ? CH_4 : CH_3;
            5'd3:    col_byte = CH_8;
            5'd4:    col_byte = CH_SEMI;
            5'd5:    col_byte = CH_2;
            5'd6:    col_byte = CH_SEMI;
            default:
            begin
                if (off[1:0] == 2'd3)
                begin
                    col_byte = (off[3:2] == 2'd2) ? CH_M : CH_SEMI;
                end
                else
                begin
                    col_byte = CH_0 + {4'd0, digits_reg[ch][off[1:0]]};
                end
            end
        endcase

        nul_sel = (idx >= SLOT_W'(NUL_BASE));
        tail    = nul_sel ? 3'(idx - SLOT_W'(NUL_BASE)) : 3'(idx - SLOT_W'(NL_BASE));
        case (tail)
            3'd0:    slot_byte = CH_ESC;
            3'd1:    slot_byte = CH_LBR;
            3'd2:    slot_byte = CH_0;
            3'd3:    slot_byte = CH_M;
            default: slot_byte = nul_sel ? CH_NUL : CH_NL;
        endcase

        if (idx < SLOT_W'(GLYPH_BASE))
        begin
            slot_byte = col_byte;
        end
        else if (idx == SLOT_W'(GLYPH_BASE))
        begin
            slot_byte = GLYPH_0;
        end
        else if (idx == SLOT_W'(GLYPH_BASE + 1))
        begin
            slot_byte = GLYPH_1;
        end
        else if (idx == SLOT_W'(GLYPH_BASE + 2))
        begin
            slot_byte = GLYPH_2;
        end
    end

    always_comb
    begin
        mask_next      = mask_reg;
        digits_next    = digits_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (adv)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = slot_byte;
            last_next      = (rest == '0);
            mask_next      = rest;
            if (rest == '0)
            begin
                busy_next = 1'b0;
            end
        end
        if (q_pop)
        begin
            mask_next   = head_job.mask;
            digits_next = head_job.digits;
            busy_next   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg     <= mask_next;
        digits_reg   <= digits_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_reg;

endmodule

>>> sv/ansi_halfblock_encoder_unit.sv
// Top level of the ANSI true-colour half-block encoder.
// Input channel: one vertical pixel pair per beat (top and bottom RGB plus
// row_first, row_last, image_last), taken when in_valid is high and
// in_stall low. in_stall rises only while the job queue is full.
// Output channel: one text byte per beat on out_byte, last_byte marking the
// final byte of each pixel pair; taken when out_valid is high and out_stall low.
// Config channel: grayscale_mode written when cfg_valid and cfg_ready are
// high; cfg_ready is always high. Write it only while the block is idle.
// A pair is written to the queue, then loaded into the sequencer, then its first byte is registered on out_byte.
// Throughput: one byte per cycle from the output sequencer while out_stall is low;
// a pair is 3 to 51 bytes (41 for two colour sequences and the glyph, plus 5 per tail).
// The front end keeps taking pairs while the queue has room, so it runs
// ahead of the sequencer by up to QUEUE_DEPTH pairs.
// A stalled output holds its byte; the sequencer waits and the queue fills.
// Reset empties the queue and clears the output valid flag, grayscale mode and the
// remembered colours, so the first pair always sends both colour sequences.
`include "ansi_halfblock_encoder_unit_defines.svh"

module ansi_halfblock_encoder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       grayscale_mode,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] top_red,
    input  logic [7:0] top_green,
    input  logic [7:0] top_blue,
    input  logic [7:0] bottom_red,
    input  logic [7:0] bottom_green,
    input  logic [7:0] bottom_blue,
    input  logic       row_first,
    input  logic       row_last,
    input  logic       image_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_byte
);
    import ahbe_pkg::*;

    logic         gray_reg, gray_next;
    logic         q_push, q_pop;
    job_t         q_push_job, head_job;
    q_status_t    q_status;
    back_status_t back_status;

    assign cfg_ready = 1'b1;
    assign gray_next = (cfg_valid && cfg_ready) ? grayscale_mode : gray_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_reg <= 1'b0;
        end
        else
        begin
            gray_reg <= gray_next;
        end
    end

    ahbe_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .grayscale_mode (gray_reg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .top_red        (top_red),
        .top_green      (top_green),
        .top_blue       (top_blue),
        .bottom_red     (bottom_red),
        .bottom_green   (bottom_green),
        .bottom_blue    (bottom_blue),
        .row_first      (row_first),
        .row_last       (row_last),
        .image_last     (image_last),
        .q_status       (q_status),
        .q_push         (q_push),
        .q_push_job     (q_push_job)
    );

    ahbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .status   (q_status)
    );

    ahbe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head_job  (head_job),
        .q_pop     (q_pop),
        .status    (back_status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

    `AHBE_ASSERT_NEXT(a_push_kept, clk, rst_n, q_push, !q_status.empty || back_status.busy, "accepted pair lost between queue and sequencer")
    `AHBE_ASSERT_NEXT(a_idle_pickup, clk, rst_n, !back_status.busy && !q_status.empty, back_status.busy, "sequencer idle with a queued pair")
    `AHBE_ASSERT_NOW(a_row_first_colours, clk, rst_n, q_push && row_first, q_push_job.mask[0] && q_push_job.mask[BG_BASE], "row start without both colour sequences")

endmodule

>>> bench/ahbe_stream_checker.sv
// Checker for the ANSI half-block encoder: predicts the text stream and compares each byte.
module ahbe_stream_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       grayscale_mode,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] top_red,
    input  logic [7:0] top_green,
    input  logic [7:0] top_blue,
    input  logic [7:0] bottom_red,
    input  logic [7:0] bottom_green,
    input  logic [7:0] bottom_blue,
    input  logic       row_first,
    input  logic       row_last,
    input  logic       image_last,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic       last_byte,
    output int         failures,
    output int         bytes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ahbe_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } text_beat_t;

    text_beat_t  text_queue[$];
    logic        gray_en;
    logic [23:0] top_rgb_seen;
    logic [23:0] bottom_rgb_seen;
    logic        rgb_known;

    function automatic logic [23:0] pack_rgb(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
        return gray_en ? {r, r, r} : {r, g, b};
    endfunction

    task automatic put_char(input logic [7:0] c);
        text_beat_t beat;
        beat.value = c;
        beat.last  = 1'b0;
        text_queue.push_back(beat);
    endtask

    task automatic put_decimal(input logic [7:0] v);
        if (v >= 8'd100)
        begin
            put_char(CH_0 + v / 8'd100);
            put_char(CH_0 + (v / 8'd10) % 8'd10);
        end
        else if (v >= 8'd10)
        begin
            put_char(CH_0 + v / 8'd10);
        end
        put_char(CH_0 + v % 8'd10);
    endtask

    task automatic put_colour(input logic [23:0] rgb, input logic background);
        put_char(CH_ESC);
        put_char(CH_LBR);
        put_char(background ? CH_4 : CH_3);
        put_char(CH_8);
        put_char(CH_SEMI);
        put_char(CH_2);
        put_char(CH_SEMI);
        put_decimal(rgb[23:16]);
        put_char(CH_SEMI);
        put_decimal(rgb[15:8]);
        put_char(CH_SEMI);
        put_decimal(rgb[7:0]);
        put_char(CH_M);
    endtask

    task automatic put_reset_tail(input logic [7:0] term);
        put_char(CH_ESC);
        put_char(CH_LBR);
        put_char(CH_0);
        put_char(CH_M);
        put_char(term);
    endtask

    task automatic encode_pair();
        logic [23:0] top_rgb;
        logic [23:0] bottom_rgb;
        text_beat_t  tail;
        top_rgb    = pack_rgb(top_red, top_green, top_blue);
        bottom_rgb = pack_rgb(bottom_red, bottom_green, bottom_blue);
        if (row_first)
            rgb_known = 1'b0;
        if (!rgb_known || top_rgb != top_rgb_seen)
            put_colour(top_rgb, 1'b0);
        if (!rgb_known || bottom_rgb != bottom_rgb_seen)
            put_colour(bottom_rgb, 1'b1);
        top_rgb_seen    = top_rgb;
        bottom_rgb_seen = bottom_rgb;
        rgb_known       = 1'b1;
        put_char(GLYPH_0);
        put_char(GLYPH_1);
        put_char(GLYPH_2);
        if (row_last)
            put_reset_tail(CH_NL);
        if (image_last)
            put_reset_tail(CH_NUL);
        // mark the final byte of this pair
        tail = text_queue.pop_back();
        tail.last = 1'b1;
        text_queue.push_back(tail);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        text_beat_t want;
        if (!rst_n)
        begin
            text_queue.delete();
            gray_en         = 1'b0;
            top_rgb_seen    = '0;
            bottom_rgb_seen = '0;
            rgb_known       = 1'b0;
            failures        = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (text_queue.size() == 0)
                begin
                    $error("out_byte expected none actual %02h", out_byte);
                    failures++;
                end
                else
                begin
                    want = text_queue.pop_front();
                    if (out_byte !== want.value)
                    begin
                        $error("out_byte expected %02h actual %02h", want.value, out_byte);
                        failures++;
                    end
                    if (last_byte !== want.last)
                    begin
                        $error("last_byte expected %0b actual %0b", want.last, last_byte);
                        failures++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                gray_en = grayscale_mode;
            if (in_valid && !in_stall)
                encode_pair();
        end
        bytes_pending = text_queue.size();
    end

endmodule

>>> bench/tb_ansi_halfblock_encoder_unit.sv
// Testbench top for the ANSI half-block encoder: stimulus, flow control and verdict.
module tb_ansi_halfblock_encoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [7:0] top_r;
        logic [7:0] top_g;
        logic [7:0] top_b;
        logic [7:0] bot_r;
        logic [7:0] bot_g;
        logic [7:0] bot_b;
        logic       first;
        logic       row_end;
        logic       image_end;
    } pixel_pair_t;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       cfg_valid      = 1'b0;
    logic       cfg_ready;
    logic       grayscale_mode = 1'b0;
    logic       in_valid       = 1'b0;
    logic       in_stall;
    logic [7:0] top_red        = '0;
    logic [7:0] top_green      = '0;
    logic [7:0] top_blue       = '0;
    logic [7:0] bottom_red     = '0;
    logic [7:0] bottom_green   = '0;
    logic [7:0] bottom_blue    = '0;
    logic       row_first      = 1'b0;
    logic       row_last       = 1'b0;
    logic       image_last     = 1'b0;
    logic       out_valid;
    logic       out_stall      = 1'b0;
    logic [7:0] out_byte;
    logic       last_byte;

    logic in_taken  = 1'b0;
    logic cfg_taken = 1'b0;
    int   quiet_cycles = 0;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   failures;
    int   bytes_pending;

    ansi_halfblock_encoder_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .grayscale_mode (grayscale_mode),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .top_red        (top_red),
        .top_green      (top_green),
        .top_blue       (top_blue),
        .bottom_red     (bottom_red),
        .bottom_green   (bottom_green),
        .bottom_blue    (bottom_blue),
        .row_first      (row_first),
        .row_last       (row_last),
        .image_last     (image_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .last_byte      (last_byte)
    );

    ahbe_stream_checker stream_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .grayscale_mode (grayscale_mode),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .top_red        (top_red),
        .top_green      (top_green),
        .top_blue       (top_blue),
        .bottom_red     (bottom_red),
        .bottom_green   (bottom_green),
        .bottom_blue    (bottom_blue),
        .row_first      (row_first),
        .row_last       (row_last),
        .image_last     (image_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .last_byte      (last_byte),
        .failures       (failures),
        .bytes_pending  (bytes_pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        in_taken  <= in_valid && !in_stall;
        cfg_taken <= cfg_valid && cfg_ready;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    function automatic pixel_pair_t make_pair(
        input logic [7:0] tr, input logic [7:0] tg, input logic [7:0] tb,
        input logic [7:0] br, input logic [7:0] bg, input logic [7:0] bb,
        input logic f, input logic re, input logic ie);
        pixel_pair_t p;
        p = '{tr, tg, tb, br, bg, bb, f, re, ie};
        return p;
    endfunction

    function automatic logic [7:0] rand_level();
        case ($urandom_range(0, 4))
            0:       return 8'($urandom_range(0, 9));
            1:       return 8'($urandom_range(10, 99));
            2:       return 8'($urandom_range(100, 255));
            3:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // call at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_pair(input pixel_pair_t p);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        top_red      <= p.top_r;
        top_green    <= p.top_g;
        top_blue     <= p.top_b;
        bottom_red   <= p.bot_r;
        bottom_green <= p.bot_g;
        bottom_blue  <= p.bot_b;
        row_first    <= p.first;
        row_last     <= p.row_end;
        image_last   <= p.image_end;
        in_valid     <= 1'b1;
        @(negedge clk);
        while (!in_taken)
            @(negedge clk);
    endtask

    task automatic set_grayscale(input logic mode);
        in_valid <= 1'b0;
        while (bytes_pending != 0)
            @(negedge clk);
        cfg_valid      <= 1'b1;
        grayscale_mode <= mode;
        @(negedge clk);
        while (!cfg_taken)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed rows and images, with some pairs carrying random flags
    task automatic random_pairs(input int count);
        pixel_pair_t p;
        int          row_left;
        int          rows_left;
        logic        starting;
        row_left  = 0;
        rows_left = 0;
        starting  = 1'b0;
        p         = '0;
        for (int i = 0; i < count; i++)
        begin
            if (row_left == 0)
            begin
                row_left = $urandom_range(1, 6);
                starting = 1'b1;
                if (rows_left == 0)
                    rows_left = $urandom_range(1, 3);
            end
            if (i == 0 || $urandom_range(0, 99) >= 35)
            begin
                p.top_r = rand_level();
                p.top_g = rand_level();
                p.top_b = rand_level();
            end
            if (i == 0 || $urandom_range(0, 99) >= 35)
            begin
                p.bot_r = rand_level();
                p.bot_g = rand_level();
                p.bot_b = rand_level();
            end
            if ($urandom_range(0, 99) < 10)
            begin
                p.bot_r = '0;
                p.bot_g = '0;
                p.bot_b = '0;
            end
            p.first     = starting;
            p.row_end   = (row_left == 1);
            p.image_end = (row_left == 1) && (rows_left == 1);
            if ($urandom_range(0, 99) < 12)
            begin
                p.first     = 1'($urandom_range(0, 1));
                p.row_end   = 1'($urandom_range(0, 1));
                p.image_end = 1'($urandom_range(0, 1));
            end
            send_pair(p);
            starting = 1'b0;
            row_left--;
            if (row_left == 0)
                rows_left--;
        end
    endtask

    initial
    begin
        send_idle_pct = 35;
        recv_idle_pct = 79;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_grayscale(1'b0);
        send_pair(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
        send_pair(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0));
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0));
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0));
        send_pair(make_pair(8'd9, 8'd10, 8'd99, 8'd100, 8'd199, 8'd255, 1'b0, 1'b1, 1'b0));
        send_pair(make_pair(8'd9, 8'd10, 8'd99, 8'd7, 8'd0, 8'd1, 1'b1, 1'b0, 1'b1));
        send_pair(make_pair(8'd1, 8'd2, 8'd3, 8'd254, 8'd128, 8'd64, 1'b1, 1'b1, 1'b1));
        send_pair(make_pair(8'd200, 8'd201, 8'd202, 8'd255, 8'd254, 8'd253, 1'b1, 1'b1, 1'b1));
        send_pair(make_pair(8'd17, 8'd34, 8'd51, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0));
        set_grayscale(1'b1);
        send_pair(make_pair(8'd128, 8'd1, 8'd2, 8'd5, 8'd255, 8'd0, 1'b1, 1'b0, 1'b0));
        send_pair(make_pair(8'd128, 8'd77, 8'd13, 8'd5, 8'd0, 8'd255, 1'b0, 1'b0, 1'b0));
        send_pair(make_pair(8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0, 1'b1, 1'b1));
        random_pairs(40);

        send_idle_pct = 79;
        recv_idle_pct = 35;
        set_grayscale(1'b0);
        random_pairs(40);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_grayscale(1'b1);
        random_pairs(20);
        set_grayscale(1'b0);
        random_pairs(20);

        in_valid <= 1'b0;
        while (bytes_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/ahbe_pkg.sv
sv/ahbe_front.sv
sv/ahbe_queue.sv
sv/ahbe_back.sv
sv/ansi_halfblock_encoder_unit.sv
bench/ahbe_stream_checker.sv
bench/tb_ansi_halfblock_encoder_unit.sv
